// ===== rtl/u8dec_pkg.sv =====
// ----------------------------------------------------------------------------
// u8dec_pkg
// Types, constants and the decode step shared by the decoder modules.
// ----------------------------------------------------------------------------
package u8dec_pkg;

	localparam logic [20:0] QMARK = 21'd63;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       string_end;
	} in_word_t;

	typedef struct packed {
		logic [20:0] code_point;
		logic        run_last;
		logic        final_char;
	} out_word_t;

	typedef logic [3:0][7:0] byte_quad_t;

	typedef enum logic {
		ST_IDLE,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		logic take_in;
		logic load_out;
		logic src_run;
		logic save_run;
	} cmd_t;

	typedef struct packed {
		logic dec_in;
		logic step_last;
	} sts_t;

	typedef struct packed {
		logic [20:0] cp;
		logic [1:0]  next_i;
		logic        last;
	} step_t;

	function automatic logic [2:0] lead_len(input logic [7:0] c);
		logic [2:0] len;
		if (c[7] == 1'b0) begin
			len = 3'd1;
		end else if (c[7:5] == 3'b110) begin
			len = 3'd2;
		end else if (c[7:4] == 4'b1110) begin
			len = 3'd3;
		end else if (c[7:3] == 5'b11110) begin
			len = 3'd4;
		end else begin
			len = 3'd0;
		end
		return len;
	endfunction

	function automatic step_t dec_step(input byte_quad_t bytes, input logic [2:0] n,
			input logic [1:0] i);
		logic [7:0] c;
		logic [7:0] b1;
		logic [7:0] b2;
		logic [7:0] b3;
		logic [1:0] i1;
		logic [1:0] i2;
		logic [1:0] i3;
		logic [2:0] len;
		logic [2:0] adv;
		logic [3:0] fit_end;
		logic [3:0] nxt;
		step_t      r;
		i1 = i + 2'd1;
		i2 = i + 2'd2;
		i3 = i + 2'd3;
		c = bytes[i];
		b1 = bytes[i1];
		b2 = bytes[i2];
		b3 = bytes[i3];
		len = lead_len(c);
		fit_end = {2'b00, i} + {1'b0, len};
		if (len == 3'd1) begin
			r.cp = {13'd0, c};
			adv = 3'd1;
		end else if (len >= 3'd2 && fit_end <= {1'b0, n}) begin
			unique case (len)
				3'd2: r.cp = {10'd0, c[4:0], b1[5:0]};
				3'd3: r.cp = {5'd0, c[3:0], b1[5:0], b2[5:0]};
				default: r.cp = {c[2:0], b1[5:0], b2[5:0], b3[5:0]};
			endcase
			adv = len;
		end else begin
			r.cp = QMARK;
			adv = 3'd1;
		end
		nxt = {2'b00, i} + {1'b0, adv};
		r.last = (nxt >= {1'b0, n});
		r.next_i = nxt[1:0];
		return r;
	endfunction

endpackage

// ===== rtl/u8dec_dp.sv =====
// ----------------------------------------------------------------------------
// u8dec_dp
// Datapath: open sequence hold, flush run buffer, decode step, output word.
// ----------------------------------------------------------------------------
module u8dec_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  u8dec_pkg::in_word_t in_word,
	input  u8dec_pkg::cmd_t     cmd,
	output u8dec_pkg::sts_t     sts,
	output u8dec_pkg::out_word_t out_word
);

	logic [2:0][7:0]       held_q;
	logic [1:0]            held_cnt_q;
	logic [2:0]            need_q;
	u8dec_pkg::byte_quad_t run_q;
	logic [2:0]            run_n_q;
	logic [1:0]            run_i_q;
	logic                  run_end_q;
	u8dec_pkg::out_word_t  out_q;

	u8dec_pkg::byte_quad_t bytes_in;
	u8dec_pkg::byte_quad_t step_bytes;
	logic [2:0]            n_in;
	logic [2:0]            step_n;
	logic [1:0]            step_i;
	logic                  step_end;
	logic [2:0]            len_b;
	logic                  dec_in;
	u8dec_pkg::step_t      step;

	assign bytes_in[0] = (held_cnt_q > 2'd0) ? held_q[0] : in_word.data_byte;
	assign bytes_in[1] = (held_cnt_q > 2'd1) ? held_q[1] : in_word.data_byte;
	assign bytes_in[2] = (held_cnt_q > 2'd2) ? held_q[2] : in_word.data_byte;
	assign bytes_in[3] = in_word.data_byte;
	assign n_in = {1'b0, held_cnt_q} + 3'd1;
	assign len_b = u8dec_pkg::lead_len(in_word.data_byte);

	always_comb begin
		if (need_q == 3'd0) begin
			dec_in = !(len_b >= 3'd2 && !in_word.string_end);
		end else begin
			dec_in = (n_in >= need_q) || in_word.string_end;
		end
	end

	assign step_bytes = cmd.src_run ? run_q : bytes_in;
	assign step_n = cmd.src_run ? run_n_q : n_in;
	assign step_i = cmd.src_run ? run_i_q : 2'd0;
	assign step_end = cmd.src_run ? run_end_q : in_word.string_end;
	assign step = u8dec_pkg::dec_step(step_bytes, step_n, step_i);

	assign sts.dec_in = dec_in;
	assign sts.step_last = step.last;
	assign out_word = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_cnt_q <= 2'd0;
			need_q <= 3'd0;
		end else if (cmd.take_in) begin
			if (dec_in) begin
				held_cnt_q <= 2'd0;
				need_q <= 3'd0;
			end else if (need_q == 3'd0) begin
				held_cnt_q <= 2'd1;
				need_q <= len_b;
			end else begin
				held_cnt_q <= held_cnt_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_in && !dec_in) begin
			held_q[held_cnt_q] <= in_word.data_byte;
		end
		if (cmd.save_run) begin
			run_i_q <= step.next_i;
			if (!cmd.src_run) begin
				run_q <= bytes_in;
				run_n_q <= n_in;
				run_end_q <= in_word.string_end;
			end
		end
		if (cmd.load_out) begin
			out_q.code_point <= step.cp;
			out_q.run_last <= step.last;
			out_q.final_char <= step.last & step_end;
		end
	end

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		need_q == 3'd0 |-> held_cnt_q == 2'd0)
		else $error("hold count not empty with no open sequence");

	a_open_fits: assert property (@(posedge clk) disable iff (!arst_n)
		need_q != 3'd0 |-> held_cnt_q != 2'd0 && {1'b0, held_cnt_q} < need_q)
		else $error("open sequence holds too many bytes");

	a_need_code: assert property (@(posedge clk) disable iff (!arst_n)
		need_q == 3'd0 || need_q == 3'd2 || need_q == 3'd3 || need_q == 3'd4)
		else $error("bad sequence length");

endmodule

// ===== rtl/u8dec_ctrl.sv =====
// ----------------------------------------------------------------------------
// u8dec_ctrl
// Controller: handshakes, flush sequencing and output register valid.
// ----------------------------------------------------------------------------
module u8dec_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            utf8_valid,
	output logic            utf8_stall,
	output logic            cp_valid,
	input  logic            cp_stall,
	input  u8dec_pkg::sts_t sts,
	output u8dec_pkg::cmd_t cmd
);

	u8dec_pkg::state_t state_q;
	u8dec_pkg::state_t state_d;
	logic              out_valid_q;
	logic              out_free;

	assign out_free = !out_valid_q || !cp_stall;
	assign cp_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= u8dec_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!cp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		utf8_stall = 1'b1;
		unique case (state_q)
			u8dec_pkg::ST_IDLE: begin
				utf8_stall = !out_free;
				cmd.take_in = utf8_valid && out_free;
				if (cmd.take_in && sts.dec_in) begin
					cmd.load_out = 1'b1;
					if (!sts.step_last) begin
						cmd.save_run = 1'b1;
						state_d = u8dec_pkg::ST_FLUSH;
					end
				end
			end
			u8dec_pkg::ST_FLUSH: begin
				cmd.src_run = 1'b1;
				if (out_free) begin
					cmd.load_out = 1'b1;
					cmd.save_run = 1'b1;
					if (sts.step_last) begin
						state_d = u8dec_pkg::ST_IDLE;
					end
				end
			end
			default: state_d = u8dec_pkg::ST_IDLE;
		endcase
	end

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> out_free)
		else $error("output word overwritten while pending");

	a_flush_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == u8dec_pkg::ST_FLUSH |-> !cmd.take_in)
		else $error("byte taken during flush");

	a_flush_emits: assert property (@(posedge clk) disable iff (!arst_n)
		$past(state_q == u8dec_pkg::ST_IDLE && state_d == u8dec_pkg::ST_FLUSH) |-> out_valid_q)
		else $error("flush entered without a word");

endmodule

// ===== rtl/utf8_to_code_point_decoder.sv =====
// ----------------------------------------------------------------------------
// utf8_to_code_point_decoder
// Lenient UTF-8 byte stream to code point decoder, end of string flush.
// ----------------------------------------------------------------------------
// One byte is taken per cycle whenever the output register is free or being
// drained and no flush is under way; a byte that finishes a character or ends
// the string yields its word in the next cycle. A string that ends inside an
// open sequence is decoded again through the single shared decode step, one
// word per cycle while the output side does not stall: up to three words, the
// first loaded as the final byte is taken, with the byte side stalled until
// the last of them is loaded.
module utf8_to_code_point_decoder (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 utf8_valid,
	output logic                 utf8_stall,
	input  u8dec_pkg::in_word_t  utf8_word,
	output logic                 cp_valid,
	input  logic                 cp_stall,
	output u8dec_pkg::out_word_t cp_word
);

	u8dec_pkg::cmd_t cmd;
	u8dec_pkg::sts_t sts;

	u8dec_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.utf8_valid (utf8_valid),
		.utf8_stall (utf8_stall),
		.cp_valid   (cp_valid),
		.cp_stall   (cp_stall),
		.sts        (sts),
		.cmd        (cmd)
	);

	u8dec_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_word  (utf8_word),
		.cmd      (cmd),
		.sts      (sts),
		.out_word (cp_word)
	);

endmodule

// ===== tb/utf8_to_code_point_decoder_test.sv =====
// ----------------------------------------------------------------------------
// utf8_to_code_point_decoder_test
// Self-checking bench for the lenient UTF-8 decoder. A byte-level predictor
// follows every accepted byte and queues the code points it should produce;
// each word leaving the block is matched field by field against the oldest
// one. Directed strings cover the byte extremes, bad leads, leads inside a
// sequence and strings cut short. Random strings follow. Both sides idle at
// random, and one stretch holds the output off long enough to fill the block.
// ----------------------------------------------------------------------------
module utf8_to_code_point_decoder_test;

	localparam int QUIET_LIMIT = 1000;
	localparam int HOLD_CYCLES = 120;

	logic                 clk;
	logic                 arst_n;
	logic                 utf8_valid;
	logic                 utf8_stall;
	u8dec_pkg::in_word_t  utf8_word;
	logic                 cp_valid;
	logic                 cp_stall;
	u8dec_pkg::out_word_t cp_word;

	u8dec_pkg::out_word_t expected_cps[$];
	logic [7:0]  open_bytes[3];
	int          open_count;
	int          open_len;
	int          bytes_sent;
	int          hold_req;
	bit          tx_idle_on;
	bit          rx_idle_on;
	bit          failed;

	utf8_to_code_point_decoder dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.utf8_valid (utf8_valid),
		.utf8_stall (utf8_stall),
		.utf8_word  (utf8_word),
		.cp_valid   (cp_valid),
		.cp_stall   (cp_stall),
		.cp_word    (cp_word)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int utf8_len(input logic [7:0] c);
		casez (c)
			8'b0???????: return 1;
			8'b110?????: return 2;
			8'b1110????: return 3;
			8'b11110???: return 4;
			default:     return 0;
		endcase
	endfunction

	function automatic logic [20:0] pack_char(input logic [3:0][7:0] run, input int at,
			input int len);
		logic [20:0] v;
		int k;
		case (len)
			2:       v = {16'd0, run[at][4:0]};
			3:       v = {17'd0, run[at][3:0]};
			default: v = {18'd0, run[at][2:0]};
		endcase
		for (k = 1; k < len; k++) begin
			v = {v[14:0], run[at + k][5:0]};
		end
		return v;
	endfunction

	// decode a few bytes from scratch and queue the words they give
	function automatic void decode_run(input logic [3:0][7:0] run, input int n,
			input logic fin);
		u8dec_pkg::out_word_t w;
		int i;
		int len;
		int cnt;
		i = 0;
		cnt = 0;
		while (i < n && cnt < 4) begin
			len = utf8_len(run[i]);
			w.run_last = 1'b0;
			w.final_char = 1'b0;
			if (len == 1) begin
				w.code_point = {13'd0, run[i]};
				i++;
			end else if (len >= 2 && i + len <= n) begin
				w.code_point = pack_char(run, i, len);
				i += len;
			end else begin
				w.code_point = u8dec_pkg::QMARK;
				i++;
			end
			expected_cps.push_back(w);
			cnt++;
		end
		if (cnt > 0) begin
			w = expected_cps.pop_back();
			w.run_last = 1'b1;
			w.final_char = fin;
			expected_cps.push_back(w);
		end
	endfunction

	function automatic void predict_byte(input logic [7:0] b, input logic fin);
		logic [3:0][7:0] run;
		int n;
		int k;
		run = '0;
		if (open_len == 0) begin
			if (utf8_len(b) >= 2 && !fin) begin
				open_bytes[0] = b;
				open_count = 1;
				open_len = utf8_len(b);
			end else begin
				run[0] = b;
				decode_run(run, 1, fin);
			end
		end else begin
			n = 0;
			for (k = 0; k < open_count; k++) begin
				run[n] = open_bytes[k];
				n++;
			end
			run[n] = b;
			n++;
			if (n >= open_len || fin) begin
				open_count = 0;
				open_len = 0;
				decode_run(run, n, fin);
			end else if (open_count < 3) begin
				open_bytes[open_count] = b;
				open_count++;
			end
		end
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic fin);
		u8dec_pkg::in_word_t w;
		int gap;
		w.data_byte = b;
		w.string_end = fin;
		gap = tx_idle_on ? $urandom_range(0, 13) : 0;
		if (gap > 0) begin
			utf8_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		utf8_valid <= 1'b1;
		utf8_word <= w;
		do @(posedge clk); while (utf8_stall);
		predict_byte(b, fin);
		bytes_sent++;
	endtask

	function automatic logic [7:0] lead_byte(input int len);
		logic [7:0] b;
		b = 8'($urandom_range(0, 255));
		case (len)
			1:       b[7] = 1'b0;
			2:       b[7:5] = 3'b110;
			3:       b[7:4] = 4'b1110;
			default: b[7:3] = 5'b11110;
		endcase
		return b;
	endfunction

	// mostly a proper continuation, now and then any byte
	function automatic logic [7:0] tail_byte();
		logic [7:0] b;
		b = 8'($urandom_range(0, 255));
		if ($urandom_range(0, 7) != 0) begin
			b[7:6] = 2'b10;
		end
		return b;
	endfunction

	task automatic send_char(input int len, input logic fin);
		int k;
		send_byte(lead_byte(len), fin && len == 1);
		for (k = 1; k < len; k++) begin
			send_byte(tail_byte(), fin && k == len - 1);
		end
	endtask

	// open sequence ended by the string at or before its last byte
	task automatic send_cut();
		int len;
		int k;
		int tails;
		len = $urandom_range(2, 4);
		tails = $urandom_range(0, len - 2);
		send_byte(lead_byte(len), 1'b0);
		for (k = 0; k < tails; k++) begin
			send_byte(tail_byte(), 1'b0);
		end
		send_byte(8'($urandom_range(0, 255)), 1'b1);
	endtask

	task automatic test_single_bytes();
		send_byte(8'h00, 1'b0);
		send_byte(8'h7F, 1'b0);
		send_byte(8'h41, 1'b1);
	endtask

	task automatic test_full_sequences();
		send_byte(8'hC0, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'hDF, 1'b0);
		send_byte(8'hBF, 1'b0);
		send_byte(8'hE0, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'hF7, 1'b0);
		send_byte(8'hBF, 1'b0);
		send_byte(8'hBF, 1'b0);
		send_byte(8'hBF, 1'b1);
	endtask

	task automatic test_bad_leads();
		send_byte(8'h80, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hF8, 1'b1);
	endtask

	task automatic test_leads_inside_sequence();
		send_byte(8'hE2, 1'b0);
		send_byte(8'hC3, 1'b0);
		send_byte(8'h28, 1'b1);
	endtask

	task automatic test_cut_short();
		send_byte(8'hF0, 1'b0);
		send_byte(8'h9F, 1'b0);
		send_byte(8'h41, 1'b1);
		send_byte(8'hC3, 1'b1);
	endtask

	task automatic test_output_backpressure();
		int k;
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b1;
		hold_req = HOLD_CYCLES;
		for (k = 0; k < 8; k++) begin
			send_char($urandom_range(1, 4), k == 7);
		end
		send_cut();
	endtask

	task automatic test_random_strings(input int n_bytes);
		int stop_at;
		int chars;
		int c;
		int mode;
		stop_at = bytes_sent + n_bytes;
		while (bytes_sent < stop_at) begin
			tx_idle_on = ($urandom_range(0, 3) != 0);
			rx_idle_on = ($urandom_range(0, 3) != 0);
			chars = $urandom_range(1, 8);
			for (c = 0; c < chars; c++) begin
				mode = $urandom_range(0, 9);
				if (mode < 7) begin
					send_char($urandom_range(1, 4), c == chars - 1);
				end else if (mode < 9) begin
					send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
				end else begin
					send_cut();
				end
			end
		end
	endtask

	// receiver: random stall per word plus an optional long hold
	initial begin
		int wait_left;
		int hold_left;
		wait_left = 0;
		hold_left = 0;
		cp_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req > 0) begin
				hold_left = hold_req;
				hold_req = 0;
			end
			if (cp_valid && !cp_stall) begin
				wait_left = rx_idle_on ? $urandom_range(0, 13) : 0;
			end else if (wait_left > 0) begin
				wait_left--;
			end
			if (hold_left > 0) begin
				hold_left--;
			end
			cp_stall <= (wait_left > 0) || (hold_left > 0);
		end
	end

	initial begin
		u8dec_pkg::out_word_t want;
		forever begin
			@(posedge clk);
			if (arst_n && cp_valid && !cp_stall) begin
				if (expected_cps.size() == 0) begin
					$error("unexpected word: code_point %0h", cp_word.code_point);
					failed = 1'b1;
				end else begin
					want = expected_cps.pop_front();
					if (cp_word.code_point !== want.code_point) begin
						$error("code_point: expected %0h, got %0h", want.code_point,
							cp_word.code_point);
						failed = 1'b1;
					end
					if (cp_word.run_last !== want.run_last) begin
						$error("run_last: expected %0b, got %0b", want.run_last,
							cp_word.run_last);
						failed = 1'b1;
					end
					if (cp_word.final_char !== want.final_char) begin
						$error("final_char: expected %0b, got %0b", want.final_char,
							cp_word.final_char);
						failed = 1'b1;
					end
				end
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((utf8_valid && !utf8_stall) || (cp_valid && !cp_stall)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
			if (quiet >= QUIET_LIMIT) begin
				$display("utf8_to_code_point_decoder_test NOT OK");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		utf8_valid = 1'b0;
		utf8_word = '0;
		open_count = 0;
		open_len = 0;
		bytes_sent = 0;
		hold_req = 0;
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		failed = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_single_bytes();
		test_full_sequences();
		test_bad_leads();
		test_leads_inside_sequence();
		test_cut_short();
		test_output_backpressure();
		test_random_strings(290);
		utf8_valid <= 1'b0;
		while (expected_cps.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (!failed) begin
			$display("utf8_to_code_point_decoder_test OK");
		end else begin
			$display("utf8_to_code_point_decoder_test NOT OK");
		end
		$finish;
	end

endmodule
